@@ hw/rtl/mesp_pkg.sv @@
// Package: shared constants and types for the supersampled escape-time pixel block
`default_nettype none
package mesp_pkg;
   localparam int FRAC_BITS_DEF       = 28;
   localparam int MAX_SUPERSAMPLE_DEF = 4;
   localparam int ITER_BITS_DEF       = 16;
   localparam int MAG_BITS            = 35;
   localparam int COORD_BITS          = 32;
   localparam int STEP_BITS           = 31;
   localparam int RATE_BITS           = 3;
   localparam int CSR_IDX_BITS        = 2;
   localparam int CSR_DATA_BITS       = 31;
   localparam int ZW                  = 64;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_ITER = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SS_RATE  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP     = 2'd2;

   // multiplier operation codes
   typedef enum logic [2:0] {
      OP_NONE = 3'd0,
      OP_GO   = 3'd1
   } mul_op_type;
endpackage
`default_nettype wire

@@ hw/rtl/mesp_mul.sv @@
// Shared fixed-point multiplier: sign-magnitude, four 32x32 partial products accumulated in turn
`default_nettype none
module mesp_mul
   import mesp_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic signed [ZW-1:0] a,
   input  wire logic signed [ZW-1:0] b,
   output logic                      done,
   output logic signed [ZW-1:0]      p
);
   localparam logic [ZW-1:0] ZSAT = {3'b000, {(ZW-3){1'b1}}};

   logic [ZW-1:0]   ua_ff, ua_in, ub_ff, ub_in;
   logic            neg_ff, neg_in;
   logic [2*ZW-1:0] acc_ff, acc_in;
   logic [1:0]      k_ff, k_in;
   logic            busy_ff, busy_in, done_ff, done_in;
   logic [31:0]     opa, opb;
   logic [63:0]     pp;
   logic [2*ZW-1:0] sh;
   logic [ZW-1:0]   r;

   always_comb begin
      opa = k_ff[0] ? ua_ff[63:32] : ua_ff[31:0];
      opb = k_ff[1] ? ub_ff[63:32] : ub_ff[31:0];
      pp  = 64'(opa) * 64'(opb);
      sh  = (2*ZW)'(pp) << (7'(k_ff[0]) * 7'd32 + 7'(k_ff[1]) * 7'd32);
   end

   always_comb begin
      ua_in = ua_ff; ub_in = ub_ff; neg_in = neg_ff; acc_in = acc_ff;
      k_in = k_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         ua_in   = a[ZW-1] ? ZW'(-a) : a;
         ub_in   = b[ZW-1] ? ZW'(-b) : b;
         neg_in  = a[ZW-1] ^ b[ZW-1];
         acc_in  = '0;
         k_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + sh;
         k_in   = k_ff + 2'd1;
         if (k_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      if ((acc_ff >> (ZW + FRAC_BITS)) != '0) r = ZSAT;
      else begin
         r = ZW'(acc_ff >> FRAC_BITS);
         if (r > ZSAT) r = ZSAT;
      end
      p = neg_ff ? -$signed(r) : $signed(r);
   end
   assign done = done_ff;

   always_ff @(posedge clock) begin
      ua_ff <= ua_in; ub_ff <= ub_in; neg_ff <= neg_in; acc_ff <= acc_in;
      k_ff <= k_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/mandelbrot_escape_pixel_supersample.sv @@
// Top level: supersampled escape-time pixel evaluation with one shared multiplier
// Each escape iteration uses five multiplier products; the bulb/cardioid test uses up to four.
// Throughput: one pixel at a time; the next is taken once the last result is registered.
// Mode search visits R*R*R*R sample pairs, one a cycle, and the mean uses a 40-step divider.
// Reset (synchronous) restores max_iterations 256, rate 1, step 0 and idles.
`default_nettype none
module mandelbrot_escape_pixel_supersample
   import mesp_pkg::*;
#(
   parameter int FRAC_BITS       = FRAC_BITS_DEF,
   parameter int MAX_SUPERSAMPLE = MAX_SUPERSAMPLE_DEF,
   parameter int ITER_BITS       = ITER_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic signed [COORD_BITS-1:0] req_pixel_real,
   input  wire logic signed [COORD_BITS-1:0] req_pixel_imag,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [ITER_BITS-1:0]             rsp_iterations,
   output logic [MAG_BITS-1:0]              rsp_magnitude,
   output logic                             rsp_in_set,
   input  wire logic                        csr_write,
   input  wire logic [CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]    csr_data
);
   localparam int NS  = MAX_SUPERSAMPLE * MAX_SUPERSAMPLE;
   localparam int SB  = (NS > 1) ? $clog2(NS) : 1;
   localparam int NB  = $clog2(NS + 1);
   localparam int RB  = $clog2(MAX_SUPERSAMPLE + 1);
   localparam int SUMB = MAG_BITS + NB;
   localparam logic signed [ZW-1:0] ONE   = ZW'(64'sd1 <<< FRAC_BITS);
   localparam logic signed [ZW-1:0] K_025 = ONE >>> 2;
   localparam logic signed [ZW-1:0] K_075 = (ONE >>> 2) * 3;
   localparam logic signed [ZW-1:0] K_M125 = -((ONE >>> 2) * 5);
   localparam logic signed [ZW-1:0] K_M075 = -((ONE >>> 2) * 3);
   localparam logic signed [ZW-1:0] K_04  = ZW'((ONE * 2 + 2) / 5);
   localparam logic signed [ZW-1:0] K_00625 = ONE >>> 4;
   localparam logic [ZW:0] ESC = (ZW+1)'(ONE) * 4;
   localparam logic signed [ZW-1:0] ZSAT = {3'b000, {(ZW-3){1'b1}}};
   localparam logic [MAG_BITS-1:0] MAG_MAX = '1;

   typedef enum logic [14:0] {
      S_IDLE = 15'd1, S_COORD = 15'd2, S_TCLS = 15'd4, S_TMUL = 15'd8,
      S_TWAIT = 15'd16, S_IMUL = 15'd32, S_IWAIT = 15'd64, S_ICHK = 15'd128,
      S_STORE = 15'd256, S_MODE = 15'd512, S_SUM = 15'd1024, S_DIV = 15'd2048,
      S_OUT = 15'd4096, S_PICK = 15'd8192, S_NEXT = 15'd16384
   } state_type;

   state_type state_ff, state_in;
   logic [ITER_BITS-1:0] maxit_ff, maxit_in;
   logic [RATE_BITS-1:0] rate_ff, rate_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic signed [COORD_BITS-1:0] re0_ff, re0_in, im0_ff, im0_in;
   logic [RB-1:0] rr_ff, rr_in, cc_ff, cc_in, side_ff, side_in;
   logic signed [ZW-1:0] cx_ff, cx_in, cy_ff, cy_in, zx_ff, zx_in, zy_ff, zy_in;
   logic signed [ZW-1:0] t0_ff, t0_in, t1_ff, t1_in, t2_ff, t2_in;
   logic [2:0] ph_ff, ph_in;
   logic [ITER_BITS-1:0] n_ff, n_in;
   logic [ZW:0] m_ff, m_in;
   logic [ITER_BITS-1:0] cnt_ff [NS];
   logic [MAG_BITS-1:0]  mag_ff [NS];
   logic [ITER_BITS-1:0] cnt_in;
   logic [MAG_BITS-1:0]  mag_in;
   logic [SB-1:0] ns_ff, ns_in, k_ff, k_in, j_ff, j_in;
   logic [NB-1:0] tot_ff, tot_in, occ_ff, occ_in, mocc_ff, mocc_in;
   logic [ITER_BITS-1:0] mcnt_ff, mcnt_in, lcnt_ff, lcnt_in;
   logic [MAG_BITS-1:0] lmag_ff, lmag_in;
   logic [SUMB-1:0] sum_ff, sum_in, rem_ff, rem_in;
   logic [6:0] dk_ff, dk_in;
   logic wr;
   logic [ITER_BITS-1:0] ocnt_ff, ocnt_in;
   logic [MAG_BITS-1:0] omag_ff, omag_in;
   logic ov_ff, ov_in;

   logic mstart, mdone;
   logic signed [ZW-1:0] ma, mb, mp;
   logic signed [ZW+1:0] xs, ys, re_w, im_w;
   logic [SUMB-1:0] rtry;
   logic [SUMB:0] rsh;

   mesp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock(clock), .reset(reset), .start(mstart), .a(ma), .b(mb),
      .done(mdone), .p(mp));

   function automatic logic signed [ZW-1:0] clampc(input logic signed [ZW+1:0] v);
      logic signed [ZW+1:0] hi, lo;
      hi = (ZW+2)'(32'sh7fffffff);
      lo = -(ZW+2)'(64'sh80000000);
      if (v > hi) return ZW'(hi);
      if (v < lo) return ZW'(lo);
      return ZW'(v);
   endfunction

   function automatic logic signed [ZW-1:0] clampz(input logic signed [ZW+1:0] v);
      if (v > (ZW+2)'(ZSAT)) return ZSAT;
      if (v < -(ZW+2)'(ZSAT)) return -ZSAT;
      return ZW'(v);
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_iterations = ocnt_ff;
   assign rsp_magnitude = omag_ff;
   assign rsp_in_set = (ocnt_ff == maxit_ff);

   always_comb begin
      xs = (ZW+2)'(re0_ff) + (ZW+2)'(cc_ff) * (ZW+2)'(step_ff);
      ys = (ZW+2)'(im0_ff) - (ZW+2)'(rr_ff) * (ZW+2)'(step_ff);
      re_w = (ZW+2)'(t0_ff) - (ZW+2)'(t1_ff) + (ZW+2)'(cx_ff);
      im_w = 2 * (ZW+2)'(mp) + (ZW+2)'(cy_ff);
      rsh  = {rem_ff, sum_ff[SUMB-1]};
      rtry = SUMB'(rsh - (SUMB+1)'(mocc_ff));
   end

   always_comb begin
      state_in = state_ff;
      maxit_in = maxit_ff; rate_in = rate_ff; step_in = step_ff;
      re0_in = re0_ff; im0_in = im0_ff; rr_in = rr_ff; cc_in = cc_ff; side_in = side_ff;
      cx_in = cx_ff; cy_in = cy_ff; zx_in = zx_ff; zy_in = zy_ff;
      t0_in = t0_ff; t1_in = t1_ff; t2_in = t2_ff; ph_in = ph_ff;
      n_in = n_ff; m_in = m_ff; cnt_in = n_ff; mag_in = '0; wr = 1'b0;
      ns_in = ns_ff; k_in = k_ff; j_in = j_ff; tot_in = tot_ff; occ_in = occ_ff;
      mocc_in = mocc_ff; mcnt_in = mcnt_ff; lcnt_in = lcnt_ff; lmag_in = lmag_ff;
      sum_in = sum_ff; rem_in = rem_ff; dk_in = dk_ff;
      ocnt_in = ocnt_ff; omag_in = omag_ff; ov_in = ov_ff;
      mstart = 1'b0; ma = zx_ff; mb = zx_ff;

      if (ov_ff && !rsp_stall) ov_in = 1'b0;
      if (csr_write) begin
         case (csr_index)
            CSR_MAX_ITER: maxit_in = ITER_BITS'(csr_data[15:0]);
            CSR_SS_RATE:  rate_in = csr_data[RATE_BITS-1:0];
            CSR_STEP:     step_in = csr_data[STEP_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               re0_in = req_pixel_real; im0_in = req_pixel_imag;
               if (rate_ff == '0) side_in = RB'(1);
               else if (32'(rate_ff) > MAX_SUPERSAMPLE) side_in = RB'(MAX_SUPERSAMPLE);
               else side_in = RB'(rate_ff);
               rr_in = '0; cc_in = '0; ns_in = '0; tot_in = '0;
               lcnt_in = maxit_ff; lmag_in = '0;
               state_in = S_COORD;
            end
         end
         S_COORD: begin
            cx_in = clampc(xs); cy_in = clampc(ys);
            state_in = S_TCLS;
         end
         S_TCLS: begin
            ph_in = '0;
            zx_in = cx_ff; zy_in = cy_ff; n_in = '0; m_in = '0;
            if (cx_ff >= K_M125 && cx_ff <= K_M075) begin
               if (cy_ff <= K_025 && cy_ff >= -K_025) begin
                  t2_in = 64'sd0; state_in = S_TMUL;
               end else state_in = S_IMUL;
            end else if (cx_ff >= K_M075 && cx_ff <= K_04 && cy_ff <= K_075
                         && cy_ff >= -K_075) begin
               t2_in = 64'sd1; state_in = S_TMUL;
            end else state_in = S_IMUL;
         end
         S_TMUL: begin
            mstart = 1'b1;
            case (ph_ff)
               3'd0: begin
                  ma = t2_ff[0] ? cx_ff - K_025 : cx_ff + ONE; mb = ma;
               end
               3'd1: begin ma = cy_ff; mb = cy_ff; end
               3'd2: begin ma = t0_ff + t1_ff; mb = t0_ff + t1_ff + cx_ff - K_025; end
               default: begin ma = cy_ff; mb = cy_ff; end
            endcase
            state_in = S_TWAIT;
         end
         S_TWAIT: begin
            if (mdone) begin
               state_in = S_TMUL;
               ph_in = ph_ff + 3'd1;
               case (ph_ff)
                  3'd0: t0_in = mp;
                  3'd1: begin
                     t1_in = mp;
                     if (!t2_ff[0]) begin
                        state_in = (t0_ff + mp <= K_00625) ? S_PICK : S_IMUL;
                        ph_in = '0;
                     end
                  end
                  3'd2: t0_in = mp;
                  default: begin
                     state_in = (t0_ff < (mp >>> 2)) ? S_PICK : S_IMUL;
                     ph_in = '0;
                  end
               endcase
            end
         end
         S_PICK: begin
            cnt_in = maxit_ff; mag_in = '0; wr = 1'b1; state_in = S_STORE;
         end
         S_IMUL: begin
            ph_in = '0;
            if (n_ff < maxit_ff && m_ff <= ESC) begin
               mstart = 1'b1; ma = zx_ff; mb = zx_ff; state_in = S_IWAIT;
            end else begin
               cnt_in = n_ff; mag_in = (m_ff > (ZW+1)'(MAG_MAX)) ? MAG_MAX : MAG_BITS'(m_ff);
               wr = 1'b1; state_in = S_STORE;
            end
         end
         S_IWAIT: begin
            if (mdone) begin
               ph_in = ph_ff + 3'd1;
               mstart = 1'b1;
               case (ph_ff)
                  3'd0: begin t0_in = mp; ma = zy_ff; mb = zy_ff; end
                  3'd1: begin t1_in = mp; ma = zx_ff; mb = zy_ff; end
                  3'd2: begin
                     zx_in = clampz(re_w); zy_in = clampz(im_w);
                     ma = clampz(re_w); mb = ma;
                  end
                  3'd3: begin t0_in = mp; ma = zy_ff; mb = zy_ff; end
                  default: begin
                     mstart = 1'b0;
                     m_in = (ZW+1)'($unsigned(t0_ff)) + (ZW+1)'($unsigned(mp));
                     n_in = n_ff + 1'b1;
                     state_in = S_IMUL;
                  end
               endcase
            end
         end
         S_STORE: begin
            if (cnt_ff[ns_ff] < lcnt_ff) begin
               lcnt_in = cnt_ff[ns_ff]; lmag_in = mag_ff[ns_ff];
            end
            tot_in = tot_ff + 1'b1;
            ns_in = ns_ff + 1'b1;
            state_in = S_COORD;
            if (cc_ff == side_ff - 1'b1) begin
               cc_in = '0;
               if (rr_ff == side_ff - 1'b1) begin
                  state_in = S_MODE; k_in = '0; j_in = '0; occ_in = '0;
                  mocc_in = '0; mcnt_in = '0;
               end else rr_in = rr_ff + 1'b1;
            end else cc_in = cc_ff + 1'b1;
         end
         S_MODE: begin
            occ_in = occ_ff + NB'(cnt_ff[j_ff] == cnt_ff[k_ff]);
            j_in = j_ff + 1'b1;
            if (NB'(j_ff) == tot_ff - 1'b1) begin
               if (occ_in > mocc_ff || (occ_in == mocc_ff && cnt_ff[k_ff] < mcnt_ff)) begin
                  mocc_in = occ_in; mcnt_in = cnt_ff[k_ff];
               end
               j_in = '0; occ_in = '0;
               k_in = k_ff + 1'b1;
               if (NB'(k_ff) == tot_ff - 1'b1) begin
                  state_in = S_SUM; k_in = '0; sum_in = '0;
               end
            end
         end
         S_SUM: begin
            if (cnt_ff[k_ff] == mcnt_ff) sum_in = sum_ff + SUMB'(mag_ff[k_ff]);
            k_in = k_ff + 1'b1;
            if (NB'(k_ff) == tot_ff - 1'b1) begin
               state_in = S_DIV; rem_in = '0; dk_in = '0;
            end
         end
         S_DIV: begin
            if (rsh >= (SUMB+1)'(mocc_ff)) begin
               rem_in = rtry; sum_in = {sum_ff[SUMB-2:0], 1'b1};
            end else begin
               rem_in = SUMB'(rsh); sum_in = {sum_ff[SUMB-2:0], 1'b0};
            end
            dk_in = dk_ff + 1'b1;
            if (dk_ff == 7'(SUMB - 1)) state_in = S_OUT;
         end
         S_OUT: begin
            if (!ov_ff || !rsp_stall) begin
               if (mocc_ff == NB'(1) || (SUMB+2)'(mocc_ff) * 4 < (SUMB+2)'(tot_ff) * 3) begin
                  ocnt_in = lcnt_ff; omag_in = lmag_ff;
               end else begin
                  ocnt_in = mcnt_ff; omag_in = MAG_BITS'(sum_ff);
               end
               ov_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      re0_ff <= re0_in; im0_ff <= im0_in; cx_ff <= cx_in; cy_ff <= cy_in;
      zx_ff <= zx_in; zy_ff <= zy_in; t0_ff <= t0_in; t1_ff <= t1_in; t2_ff <= t2_in;
      n_ff <= n_in; m_ff <= m_in; ph_ff <= ph_in; rr_ff <= rr_in; cc_ff <= cc_in;
      side_ff <= side_in; ns_ff <= ns_in; k_ff <= k_in; j_ff <= j_in; tot_ff <= tot_in;
      occ_ff <= occ_in; mocc_ff <= mocc_in; mcnt_ff <= mcnt_in; lcnt_ff <= lcnt_in;
      lmag_ff <= lmag_in; sum_ff <= sum_in; rem_ff <= rem_in;
      dk_ff <= dk_in; ocnt_ff <= ocnt_in; omag_ff <= omag_in;
      if (wr) begin
         cnt_ff[ns_ff] <= cnt_in; mag_ff[ns_ff] <= mag_in;
      end
      if (reset) begin
         state_ff <= S_IDLE; ov_ff <= 1'b0;
         maxit_ff <= ITER_BITS'(256); rate_ff <= RATE_BITS'(1); step_ff <= '0;
      end else begin
         state_ff <= state_in; ov_ff <= ov_in;
         maxit_ff <= maxit_in; rate_ff <= rate_in; step_ff <= step_in;
      end
   end
endmodule
`default_nettype wire

@@ bench/tb_mandelbrot_escape_pixel_supersample.sv @@
// Testbench: supersampled escape-time pixel block checked against a built-in predictor
`default_nettype none
module tb_mandelbrot_escape_pixel_supersample;
   import mesp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam longint ONE_FX    = 64'sd1 << FRAC_BITS_DEF;
   localparam longint ZSAT      = (64'sd1 <<< 61) - 1;
   localparam longint MAG_MAX   = (64'sd1 <<< MAG_BITS) - 1;
   localparam longint K_M125    = -((ONE_FX >>> 2) * 5);
   localparam longint K_M075    = -((ONE_FX >>> 2) * 3);
   localparam longint K_025     = ONE_FX >>> 2;
   localparam longint K_075     = (ONE_FX >>> 2) * 3;
   localparam longint K_04      = (ONE_FX * 2 + 2) / 5;
   localparam longint K_00625   = ONE_FX >>> 4;
   localparam longint ESC_LIM   = ONE_FX * 4;
   localparam int     IDLE_PCT  = 23;
   localparam int     HOLD_LEN  = 600;
   localparam int     WD_LIMIT  = 400000;

   typedef struct packed {
      logic [ITER_BITS_DEF-1:0] iterations;
      logic [MAG_BITS-1:0]      magnitude;
      logic                     in_set;
   } pixel_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [COORD_BITS-1:0] req_pixel_real = '0;
   logic signed [COORD_BITS-1:0] req_pixel_imag = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ITER_BITS_DEF-1:0] rsp_iterations;
   logic [MAG_BITS-1:0] rsp_magnitude;
   logic rsp_in_set;
   logic csr_write = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   pixel_result_type pending_pixels[$];
   int  mismatches = 0;
   int  pixels_sent = 0;
   int  pixels_checked = 0;
   int  idle_cycles = 0;
   bit  no_idle = 1'b0;
   int  hold_seq = 0;

   // current register copy
   int     lim_iter = 256;
   int     grid_rate = 1;
   longint grid_step = 0;

   always #1 clock = ~clock;

   mandelbrot_escape_pixel_supersample u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pixel_real(req_pixel_real), .req_pixel_imag(req_pixel_imag),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_iterations(rsp_iterations), .rsp_magnitude(rsp_magnitude),
      .rsp_in_set(rsp_in_set),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   function automatic longint fx_product(longint a, longint b);
      logic [63:0]  ua, ub;
      logic [127:0] p;
      logic         neg;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      p = {64'd0, ua} * {64'd0, ub};
      p = p >> FRAC_BITS_DEF;
      if (p > 128'(ZSAT)) p = 128'(ZSAT);
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   function automatic longint clamp_z(longint v);
      if (v > ZSAT) return ZSAT;
      if (v < -ZSAT) return -ZSAT;
      return v;
   endfunction

   function automatic longint clamp_coord(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic bit in_bulb_or_cardioid(longint x, longint y);
      longint dx, xa, q;
      if (x >= K_M125 && x <= K_M075) begin
         if (y <= K_025 && y >= -K_025) begin
            dx = x + ONE_FX;
            return fx_product(dx, dx) + fx_product(y, y) <= K_00625;
         end
         return 1'b0;
      end
      if (x >= K_M075 && x <= K_04 && y <= K_075 && y >= -K_075) begin
         xa = x - K_025;
         q = fx_product(xa, xa) + fx_product(y, y);
         return fx_product(q, q + xa) < (fx_product(y, y) >>> 2);
      end
      return 1'b0;
   endfunction

   task automatic escape_sample(input longint cx, input longint cy,
                                output int cnt, output longint mag);
      longint zx, zy, re, im, m;
      cnt = 0;
      m = 0;
      zx = cx;
      zy = cy;
      if (in_bulb_or_cardioid(cx, cy)) begin
         cnt = lim_iter;
         mag = 0;
         return;
      end
      while (cnt < lim_iter && m <= ESC_LIM) begin
         re = fx_product(zx, zx) - fx_product(zy, zy) + cx;
         im = 2 * fx_product(zx, zy) + cy;
         zx = clamp_z(re);
         zy = clamp_z(im);
         m = fx_product(zx, zx) + fx_product(zy, zy);
         cnt++;
      end
      mag = (m > MAG_MAX) ? MAG_MAX : m;
   endtask

   task automatic predict_pixel(input logic signed [31:0] pr, input logic signed [31:0] pi,
                                output pixel_result_type res);
      int     cnts[16];
      longint mags[16];
      int     rate, n, occ, mode_occ, mode_cnt, low_cnt, best_cnt;
      longint low_mag, best_mag, sum, x, y;
      rate = (grid_rate == 0) ? 1 : (grid_rate > 4 ? 4 : grid_rate);
      n = 0;
      low_cnt = lim_iter;
      low_mag = 0;
      mode_occ = 0;
      mode_cnt = 0;
      sum = 0;
      for (int r = 0; r < rate; r++) begin
         y = clamp_coord(longint'(pi) - r * grid_step);
         for (int c = 0; c < rate; c++) begin
            x = clamp_coord(longint'(pr) + c * grid_step);
            escape_sample(x, y, cnts[n], mags[n]);
            if (cnts[n] < low_cnt) begin
               low_cnt = cnts[n];
               low_mag = mags[n];
            end
            n++;
         end
      end
      for (int k = 0; k < n; k++) begin
         occ = 0;
         for (int j = 0; j < n; j++)
            if (cnts[j] == cnts[k]) occ++;
         if (occ > mode_occ || (occ == mode_occ && cnts[k] < mode_cnt)) begin
            mode_occ = occ;
            mode_cnt = cnts[k];
         end
      end
      for (int k = 0; k < n; k++)
         if (cnts[k] == mode_cnt) sum += mags[k];
      if (mode_occ == 1 || mode_occ * 4 < n * 3) begin
         best_cnt = low_cnt;
         best_mag = low_mag;
      end else begin
         best_cnt = mode_cnt;
         best_mag = sum / mode_occ;
      end
      res.iterations = best_cnt[15:0];
      res.magnitude  = best_mag[MAG_BITS-1:0];
      res.in_set     = (best_cnt == lim_iter);
   endtask

   // receiver: random stalls and the long hold-off
   always @(posedge clock) begin
      static int hold_left = 0;
      static int hold_seen = 0;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HOLD_LEN;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // check each result transaction
   always @(posedge clock) begin
      pixel_result_type want, got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_iterations, rsp_magnitude, rsp_in_set};
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: iter %0d mag %0d in_set %0b",
                        got.iterations, got.magnitude, got.in_set);
         end else begin
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: iter exp %0d got %0d, mag exp %0d got %0d, in_set exp %0b got %0b",
                           want.iterations, got.iterations, want.magnitude, got.magnitude,
                           want.in_set, got.in_set);
            end
         end
      end
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", WD_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_pixel(input logic signed [31:0] pr, input logic signed [31:0] pi);
      pixel_result_type res;
      if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_pixel_real <= pr;
      req_pixel_imag <= pi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_pixel(pr, pi, res);
      pending_pixels.insert(pending_pixels.size(), res);
      pixels_sent++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input longint value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_MAX_ITER: lim_iter  = int'(value[15:0]);
         CSR_SS_RATE:  grid_rate = int'(value[2:0]);
         CSR_STEP:     grid_step = longint'(value[30:0]);
         default: ;
      endcase
   endtask

   task automatic configure(input longint iters, input longint rate, input longint step);
      drain();
      write_reg(CSR_MAX_ITER, iters);
      write_reg(CSR_SS_RATE, rate);
      write_reg(CSR_STEP, step);
   endtask

   function automatic logic signed [31:0] plane_coord();
      // mostly within +-2.5, sometimes any value
      if ($urandom_range(9) == 0) return $urandom;
      return $signed($urandom_range(32'd1342177280)) - 32'sd671088640;
   endfunction

   task automatic random_pixels(input int count);
      for (int i = 0; i < count; i++)
         send_pixel(plane_coord(), plane_coord());
   endtask

   task automatic test_reset_defaults;
      send_pixel(32'sd0, 32'sd0);
      send_pixel(-32'sd268435456, 32'sd0);
      send_pixel(32'sh10000000, 32'sh10000000);
   endtask

   task automatic test_field_extremes;
      configure(40, 1, 0);
      send_pixel(32'sh80000000, 32'sh80000000);
      send_pixel(32'sh7fffffff, 32'sh7fffffff);
      send_pixel(32'sh80000000, 32'sh7fffffff);
      send_pixel(32'sh7fffffff, 32'sh80000000);
      send_pixel(-32'sd1, -32'sd1);
      send_pixel(32'sd1, 32'sd0);
      configure(65535, 1, 0);
      send_pixel(32'sd0, 32'sd0);
      send_pixel(-32'sd268435456, 32'sd0);
      send_pixel(32'sh20000000, 32'sh20000000);
   endtask

   task automatic test_grid_clamping;
      configure(24, 0, 32'h01000000);
      send_pixel(-32'sd134217728, 32'sd100000000);
      configure(24, 7, 31'h7fffffff);
      send_pixel(32'sh70000000, 32'shf0000000);
      send_pixel(-32'sd268435456, 32'sd0);
      // unknown index leaves everything as it is
      drain();
      write_reg(CSR_UNUSED, 31'h7fffffff);
      send_pixel(32'sh80000000, 32'sh7fffffff);
   endtask

   task automatic test_zero_limit;
      configure(0, 2, 32'h00400000);
      send_pixel(32'sd0, 32'sd0);
      send_pixel(32'sh40000000, 32'sh40000000);
      configure(1, 3, 32'h00100000);
      send_pixel(-32'sd536870912, 32'sd0);
      send_pixel(32'sh08000000, 32'sh08000000);
   endtask

   task automatic test_mode_selection;
      configure(30, 2, 32'h00010000);
      send_pixel(-32'sd201326592, 32'sd26843545);
      send_pixel(32'sd100663296, 32'sd167772160);
      configure(30, 4, 32'h00200000);
      send_pixel(-32'sd201326592, 32'sd53687091);
      send_pixel(-32'sd402653184, 32'sd20000000);
   endtask

   task automatic test_random_settings;
      configure(32, 1, 0);
      random_pixels(50);
      configure(48, 2, $urandom_range(32'h01000000));
      random_pixels(50);
      configure(20, 4, $urandom_range(32'h00800000));
      random_pixels(35);
      configure(1, 3, $urandom & 32'h7fffffff);
      random_pixels(30);
      configure(64, 5, $urandom_range(32'h00400000));
      random_pixels(25);
      configure($urandom_range(2, 40), $urandom_range(1, 3), $urandom & 32'h7fffffff);
      random_pixels(30);
   endtask

   task automatic test_back_pressure;
      configure(16, 1, 0);
      no_idle = 1'b1;
      random_pixels(15);
      hold_seq <= hold_seq + 1;
      random_pixels(20);
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_field_extremes();
      test_grid_clamping();
      test_zero_limit();
      test_mode_selection();
      test_random_settings();
      test_back_pressure();
      drain();
      repeat (200) @(posedge clock);
      $display("covered %0d pixels (%0d checked) over limits 0..65535, grid sides 0..7,",
               pixels_sent, pixels_checked);
      $display("steps 0..max, bulb and cardioid points, saturation and a long output hold-off");
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ files.f @@
hw/rtl/mesp_pkg.sv
hw/rtl/mesp_mul.sv
hw/rtl/mandelbrot_escape_pixel_supersample.sv
bench/tb_mandelbrot_escape_pixel_supersample.sv
